// ===== rtl/ibc_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package ibc_pkg;

  // Sample and result widths fixed by the sensor packet format.
  localparam int unsigned SAMPLE_W  = 16;
  localparam int unsigned GOFF_W    = 15;
  localparam int unsigned NUM_AXES  = 3;
  localparam int unsigned NUM_CH    = 2 * NUM_AXES;
  localparam int unsigned CH_W      = $clog2(NUM_CH);
  localparam int unsigned CFG_IDX_W = 2;

  typedef logic signed [SAMPLE_W-1:0] sample_t;
  typedef logic        [SAMPLE_W-1:0] word_t;
  typedef logic signed [GOFF_W-1:0]   goff_t;

  // One standard gravity in accelerometer counts.
  localparam sample_t GRAVITY_COUNTS = 16'sd16384;

  // Channel order in the accumulator and the averaging pass.
  localparam logic [CH_W-1:0] CH_ACCEL_X = 3'd0;
  localparam logic [CH_W-1:0] CH_ACCEL_Z = 3'd2;
  localparam logic [CH_W-1:0] CH_LAST    = 3'd5;

  // Configuration register indices.
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_TRIM_X = 2'd0,
    CFG_TRIM_Y = 2'd1,
    CFG_TRIM_Z = 2'd2
  } cfg_idx_e;

endpackage

`default_nettype wire

// ===== rtl/ibc_if.sv =====
`timescale 1ns / 1ps
`default_nettype none

// Packet channel: one at-rest sample set per transfer.
interface ibc_in_if;
  logic                valid;
  logic                ready;
  ibc_pkg::sample_t    accel_x;
  ibc_pkg::sample_t    accel_y;
  ibc_pkg::sample_t    accel_z;
  ibc_pkg::sample_t    gyro_x;
  ibc_pkg::sample_t    gyro_y;
  ibc_pkg::sample_t    gyro_z;
  logic                last;

  modport source (output valid, accel_x, accel_y, accel_z, gyro_x, gyro_y, gyro_z, last,
                  input ready);
  modport sink   (input valid, accel_x, accel_y, accel_z, gyro_x, gyro_y, gyro_z, last,
                  output ready);
endinterface

// Result channel: averages and offset words for one calibration run.
interface ibc_out_if;
  logic                valid;
  logic                ready;
  ibc_pkg::sample_t    accel_avg_x;
  ibc_pkg::sample_t    accel_avg_y;
  ibc_pkg::sample_t    accel_avg_z;
  ibc_pkg::sample_t    gyro_avg_x;
  ibc_pkg::sample_t    gyro_avg_y;
  ibc_pkg::sample_t    gyro_avg_z;
  ibc_pkg::goff_t      gyro_offset_x;
  ibc_pkg::goff_t      gyro_offset_y;
  ibc_pkg::goff_t      gyro_offset_z;
  ibc_pkg::word_t      accel_offset_x;
  ibc_pkg::word_t      accel_offset_y;
  ibc_pkg::word_t      accel_offset_z;

  modport source (output valid, accel_avg_x, accel_avg_y, accel_avg_z,
                  gyro_avg_x, gyro_avg_y, gyro_avg_z,
                  gyro_offset_x, gyro_offset_y, gyro_offset_z,
                  accel_offset_x, accel_offset_y, accel_offset_z,
                  input ready);
  modport sink   (input valid, accel_avg_x, accel_avg_y, accel_avg_z,
                  gyro_avg_x, gyro_avg_y, gyro_avg_z,
                  gyro_offset_x, gyro_offset_y, gyro_offset_z,
                  accel_offset_x, accel_offset_y, accel_offset_z,
                  output ready);
endinterface

// Register write channel.
interface ibc_cfg_if;
  logic                              valid;
  logic                              ready;
  logic [ibc_pkg::CFG_IDX_W-1:0]     index;
  ibc_pkg::word_t                    data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

// ===== rtl/imu_bias_calibration.sv =====
`timescale 1ns / 1ps
`default_nettype none

// At-rest bias calibration for a three-axis accelerometer and gyroscope.
// Packets are summed one per cycle while the block is idle and the packet
// marked last is awaited; up to MAX_PACKETS are summed and later ones are
// dropped. The last packet starts the averaging pass: the six sums, each
// SUM_W = 16 + clog2(MAX_PACKETS + 1) bits wide, go one after another
// through a single restoring divider that yields one quotient bit per cycle.
// The packet input is not ready during the pass. The result then waits in
// an output register, and the next run of packets is taken while it does.
// The user must write trim registers through the configuration channel only
// while the block is idle; the block itself does not enforce it. Writes to
// indices beyond the three trims are ignored.
module imu_bias_calibration #(
  parameter int unsigned MAX_PACKETS = 64
) (
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  ibc_in_if.sink     in_i,
  ibc_cfg_if.sink    cfg_i,
  ibc_out_if.source  out_o
);
  import ibc_pkg::*;

  localparam int unsigned CNT_W = $clog2(MAX_PACKETS + 1);
  localparam int unsigned SUM_W = SAMPLE_W + CNT_W;

  typedef enum logic [3:0] {
    S_IDLE  = 4'b0001,
    S_START = 4'b0010,
    S_WAIT  = 4'b0100,
    S_OUT   = 4'b1000
  } state_e;

  state_e                  state_q, state_d;
  logic [CH_W-1:0]         chan_q, chan_d;
  logic                    in_accept;
  logic                    load;
  sample_t                 samples [NUM_CH];
  logic signed [SUM_W-1:0] sums [NUM_CH];
  logic [CNT_W-1:0]        count;
  logic                    full;
  logic                    div_done;
  sample_t                 div_quo;
  sample_t                 avg_q [NUM_CH];
  sample_t                 trim_q [NUM_AXES];

  sample_t                 aavg [NUM_AXES];
  sample_t                 a_adj [NUM_AXES];
  sample_t                 a_div8 [NUM_AXES];
  word_t                   a_word [NUM_AXES];
  logic signed [SAMPLE_W:0] g_neg [NUM_AXES];
  logic signed [SAMPLE_W:0] g_adj [NUM_AXES];
  logic signed [SAMPLE_W:0] g_div4 [NUM_AXES];

  logic                    out_valid_q;
  sample_t                 o_aavg_q [NUM_AXES];
  sample_t                 o_gavg_q [NUM_AXES];
  goff_t                   o_goff_q [NUM_AXES];
  word_t                   o_aoff_q [NUM_AXES];

  // Packet channel handshake.
  assign in_i.ready = (state_q == S_IDLE);
  assign in_accept  = in_i.valid && in_i.ready;

  assign samples[0] = in_i.accel_x;
  assign samples[1] = in_i.accel_y;
  assign samples[2] = in_i.accel_z;
  assign samples[3] = in_i.gyro_x;
  assign samples[4] = in_i.gyro_y;
  assign samples[5] = in_i.gyro_z;

  // Trim registers.
  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NUM_AXES; i++) begin
        trim_q[i] <= '0;
      end
    end else if (cfg_i.valid && cfg_i.ready) begin
      unique case (cfg_i.index)
        CFG_TRIM_X: trim_q[0] <= sample_t'(cfg_i.data);
        CFG_TRIM_Y: trim_q[1] <= sample_t'(cfg_i.data);
        CFG_TRIM_Z: trim_q[2] <= sample_t'(cfg_i.data);
        default: ;
      endcase
    end
  end

  // Running sums.
  ibc_accum #(
    .MAX_PACKETS (MAX_PACKETS)
  ) u_accum (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .acc_en_i  (in_accept && !full),
    .clear_i   (load),
    .samples_i (samples),
    .sums_o    (sums),
    .count_o   (count),
    .full_o    (full)
  );

  // Shared divider for the six averages.
  ibc_div #(
    .NUM_W (SUM_W),
    .DEN_W (CNT_W)
  ) u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (state_q == S_START),
    .num_i   (sums[chan_q]),
    .den_i   (count),
    .done_o  (div_done),
    .quo_o   (div_quo)
  );

  // Sequencer over the six channels.
  always_comb begin
    state_d = state_q;
    chan_d  = chan_q;
    unique case (state_q)
      S_IDLE: begin
        if (in_accept && in_i.last) begin
          state_d = S_START;
          chan_d  = CH_ACCEL_X;
        end
      end
      S_START: begin
        state_d = S_WAIT;
      end
      S_WAIT: begin
        if (div_done) begin
          if (chan_q == CH_LAST) begin
            state_d = S_OUT;
          end else begin
            state_d = S_START;
            chan_d  = chan_q + CH_W'(1);
          end
        end
      end
      S_OUT: begin
        if (load) begin
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      chan_q  <= CH_ACCEL_X;
    end else begin
      state_q <= state_d;
      chan_q  <= chan_d;
    end
  end

  // Averages as they leave the divider.
  always_ff @(posedge clk_i) begin
    if (state_q == S_WAIT && div_done) begin
      avg_q[chan_q] <= div_quo;
    end
  end

  // Gravity removal and offset words.
  always_comb begin
    for (int i = 0; i < NUM_AXES; i++) begin
      aavg[i] = avg_q[i];
    end
    if (avg_q[CH_ACCEL_Z] > 0) begin
      aavg[2] = avg_q[CH_ACCEL_Z] - GRAVITY_COUNTS;
    end else begin
      aavg[2] = avg_q[CH_ACCEL_Z] + GRAVITY_COUNTS;
    end
    for (int i = 0; i < NUM_AXES; i++) begin
      // Division by 8 and by 4, rounded toward zero.
      a_adj[i]  = aavg[i] + sample_t'({{(SAMPLE_W-3){1'b0}}, {3{aavg[i][SAMPLE_W-1]}}});
      a_div8[i] = a_adj[i] >>> 3;
      a_word[i] = word_t'(trim_q[i] - a_div8[i]) | {{(SAMPLE_W-1){1'b0}}, trim_q[i][0]};
      g_neg[i]  = -{avg_q[NUM_AXES+i][SAMPLE_W-1], avg_q[NUM_AXES+i]};
      g_adj[i]  = g_neg[i] + {{(SAMPLE_W-1){1'b0}}, {2{g_neg[i][SAMPLE_W]}}};
      g_div4[i] = g_adj[i] >>> 2;
    end
  end

  // Output register; the result stays until the sink takes it.
  assign load = (state_q == S_OUT) && (!out_valid_q || out_o.ready);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (load) begin
      out_valid_q <= 1'b1;
    end else if (out_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      for (int i = 0; i < NUM_AXES; i++) begin
        o_aavg_q[i] <= aavg[i];
        o_gavg_q[i] <= avg_q[NUM_AXES+i];
        o_goff_q[i] <= goff_t'(g_div4[i][GOFF_W-1:0]);
        o_aoff_q[i] <= a_word[i];
      end
    end
  end

  assign out_o.valid          = out_valid_q;
  assign out_o.accel_avg_x    = o_aavg_q[0];
  assign out_o.accel_avg_y    = o_aavg_q[1];
  assign out_o.accel_avg_z    = o_aavg_q[2];
  assign out_o.gyro_avg_x     = o_gavg_q[0];
  assign out_o.gyro_avg_y     = o_gavg_q[1];
  assign out_o.gyro_avg_z     = o_gavg_q[2];
  assign out_o.gyro_offset_x  = o_goff_q[0];
  assign out_o.gyro_offset_y  = o_goff_q[1];
  assign out_o.gyro_offset_z  = o_goff_q[2];
  assign out_o.accel_offset_x = o_aoff_q[0];
  assign out_o.accel_offset_y = o_aoff_q[1];
  assign out_o.accel_offset_z = o_aoff_q[2];

endmodule

`default_nettype wire

// ===== rtl/ibc_accum.sv =====
`timescale 1ns / 1ps
`default_nettype none

module ibc_accum #(
  parameter int unsigned MAX_PACKETS = 64
) (
  input  wire logic                                      clk_i,
  input  wire logic                                      rst_ni,
  input  wire logic                                      acc_en_i,
  input  wire logic                                      clear_i,
  input  wire ibc_pkg::sample_t                          samples_i [ibc_pkg::NUM_CH],
  output logic signed [ibc_pkg::SAMPLE_W+$clog2(MAX_PACKETS+1)-1:0]
                                                         sums_o [ibc_pkg::NUM_CH],
  output logic        [$clog2(MAX_PACKETS+1)-1:0]        count_o,
  output logic                                           full_o
);
  import ibc_pkg::*;

  localparam int unsigned CNT_W = $clog2(MAX_PACKETS + 1);
  localparam int unsigned SUM_W = SAMPLE_W + CNT_W;

  logic signed [SUM_W-1:0] sums_q [NUM_CH];
  logic        [CNT_W-1:0] count_q;

  // Running sums and packet count; cleared when a result has been handed on.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NUM_CH; i++) begin
        sums_q[i] <= '0;
      end
      count_q <= '0;
    end else if (clear_i) begin
      for (int i = 0; i < NUM_CH; i++) begin
        sums_q[i] <= '0;
      end
      count_q <= '0;
    end else if (acc_en_i) begin
      for (int i = 0; i < NUM_CH; i++) begin
        sums_q[i] <= sums_q[i] +
                     {{(SUM_W-SAMPLE_W){samples_i[i][SAMPLE_W-1]}}, samples_i[i]};
      end
      count_q <= count_q + CNT_W'(1);
    end
  end

  assign sums_o  = sums_q;
  assign count_o = count_q;
  assign full_o  = (count_q == CNT_W'(MAX_PACKETS));

endmodule

`default_nettype wire

// ===== rtl/ibc_div.sv =====
`timescale 1ns / 1ps
`default_nettype none

// Restoring divider, one quotient bit per cycle. Divides a signed sum by an
// unsigned non-zero count, truncating toward zero.
module ibc_div #(
  parameter int unsigned NUM_W = 23,
  parameter int unsigned DEN_W = 7
) (
  input  wire logic                    clk_i,
  input  wire logic                    rst_ni,
  input  wire logic                    start_i,
  input  wire logic signed [NUM_W-1:0] num_i,
  input  wire logic        [DEN_W-1:0] den_i,
  output logic                         done_o,
  output ibc_pkg::sample_t             quo_o
);
  import ibc_pkg::*;

  localparam int unsigned CW = $clog2(NUM_W);

  logic             busy_q;
  logic             done_q;
  logic [CW-1:0]    cnt_q;
  logic [DEN_W-1:0] rem_q, rem_d;
  logic [NUM_W-1:0] quo_q, quo_d;
  logic             neg_q;
  logic [NUM_W-1:0] mag;
  logic [DEN_W:0]   trial;
  logic [DEN_W:0]   diff;
  logic             ge;
  logic [NUM_W-1:0] res;

  assign mag = num_i[NUM_W-1] ? NUM_W'(-num_i) : NUM_W'(num_i);

  // One trial subtraction of the shifted remainder.
  always_comb begin
    trial = {rem_q, quo_q[NUM_W-1]};
    diff  = trial - {1'b0, den_i};
    ge    = (trial >= {1'b0, den_i});
    rem_d = ge ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
    quo_d = {quo_q[NUM_W-2:0], ge};
  end

  // Control: busy for NUM_W steps, then a one-cycle done pulse.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else if (start_i) begin
      busy_q <= 1'b1;
      done_q <= 1'b0;
    end else if (busy_q) begin
      if (cnt_q == '0) begin
        busy_q <= 1'b0;
        done_q <= 1'b1;
      end
    end else begin
      done_q <= 1'b0;
    end
  end

  // Datapath registers.
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      cnt_q <= CW'(NUM_W - 1);
      rem_q <= '0;
      quo_q <= mag;
      neg_q <= num_i[NUM_W-1];
    end else if (busy_q) begin
      cnt_q <= cnt_q - CW'(1);
      rem_q <= rem_d;
      quo_q <= quo_d;
    end
  end

  assign res    = neg_q ? (~quo_q + NUM_W'(1)) : quo_q;
  assign quo_o  = sample_t'(res[SAMPLE_W-1:0]);
  assign done_o = done_q;

endmodule

`default_nettype wire

// ===== rtl/ibc_checker.sv =====
`timescale 1ns / 1ps
`default_nettype none

module ibc_checker (
  input wire logic              clk_i,
  input wire logic              rst_ni,
  input wire logic              in_valid_i,
  input wire logic              in_ready_i,
  input wire logic              in_last_i,
  input wire logic              out_valid_i,
  input wire logic              out_ready_i,
  input wire ibc_pkg::sample_t  gyro_avg_x_i,
  input wire ibc_pkg::goff_t    gyro_offset_x_i,
  input wire ibc_pkg::word_t    accel_offset_x_i
);
  import ibc_pkg::*;

  logic signed [SAMPLE_W:0] g_neg;
  logic signed [SAMPLE_W:0] g_adj;
  logic signed [SAMPLE_W:0] g_div4;

  // Expected gyro x offset from the gyro x average on the same result.
  always_comb begin
    g_neg  = -{gyro_avg_x_i[SAMPLE_W-1], gyro_avg_x_i};
    g_adj  = g_neg + {{(SAMPLE_W-1){1'b0}}, {2{g_neg[SAMPLE_W]}}};
    g_div4 = g_adj >>> 2;
  end

  // A stalled result stays offered.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i)
    else $error("result withdrawn while stalled");

  // A stalled result keeps its payload.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> $stable(gyro_offset_x_i) && $stable(accel_offset_x_i))
    else $error("result payload changed while stalled");

  // The last packet starts the averaging pass, which blocks new packets.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_i && in_last_i |=> !in_ready_i)
    else $error("packet input still ready after last packet");

  // A packet that is not last leaves the packet input ready in the next cycle.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_i && !in_last_i |=> in_ready_i)
    else $error("packet input stalled after a packet that is not last");

  // The gyro offset is the negated average over four.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> gyro_offset_x_i == goff_t'(g_div4[GOFF_W-1:0]))
    else $error("gyro x offset does not match gyro x average");

endmodule

bind imu_bias_calibration ibc_checker u_ibc_checker (
  .clk_i            (clk_i),
  .rst_ni           (rst_ni),
  .in_valid_i       (in_i.valid),
  .in_ready_i       (in_i.ready),
  .in_last_i        (in_i.last),
  .out_valid_i      (out_o.valid),
  .out_ready_i      (out_o.ready),
  .gyro_avg_x_i     (out_o.gyro_avg_x),
  .gyro_offset_x_i  (out_o.gyro_offset_x),
  .accel_offset_x_i (out_o.accel_offset_x)
);

`default_nettype wire

// ===== tb/tb_imu_bias_calibration.sv =====
`timescale 1ns / 1ps

module tb_imu_bias_calibration;
  import ibc_pkg::*;

  localparam int unsigned MAX_PACKETS  = 64;
  // Settle time covers the averaging pass at 64 packets, with a margin on top.
  localparam int unsigned SETTLE_CYCLES = 200;
  localparam int unsigned HOLD_CYCLES   = 600;
  localparam longint      LIMIT_CYCLES  = 1000000;
  localparam int unsigned MAX_REPORTS   = 10;
  localparam int unsigned RUN_ITEMS     = 480;
  // Index beyond the three trim registers; writes to it are dropped.
  localparam logic [CFG_IDX_W-1:0] CFG_IDX_SPARE = 2'd3;

  typedef enum int unsigned {
    FILL_RANDOM,
    FILL_AT_REST,
    FILL_EXTREME
  } fill_e;

  typedef struct packed {
    sample_t [2:0] accel;
    sample_t [2:0] gyro;
    logic          last;
  } packet_t;

  typedef struct packed {
    sample_t [2:0] accel_avg;
    sample_t [2:0] gyro_avg;
    goff_t   [2:0] gyro_off;
    word_t   [2:0] accel_off;
  } calib_result_t;

  logic clk;
  logic rst_n;

  ibc_in_if  pkt_if ();
  ibc_out_if res_if ();
  ibc_cfg_if cfg_if ();

  imu_bias_calibration #(
    .MAX_PACKETS (MAX_PACKETS)
  ) u_dut (
    .clk_i  (clk),
    .rst_ni (rst_n),
    .in_i   (pkt_if),
    .cfg_i  (cfg_if),
    .out_o  (res_if)
  );

  // Calibration state mirrored from the block.
  int            accel_sum [3];
  int            gyro_sum  [3];
  int unsigned   packets_held;
  sample_t       trim      [3];
  calib_result_t result_q  [$];

  int unsigned mismatches;
  int unsigned items_sent;
  int unsigned send_idle_pct;
  int unsigned recv_idle_pct;
  bit          hold_req;
  int unsigned hold_left;
  longint      cycles;

  // Clock.
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Averages and offset words for the run that has just been closed.
  function automatic calib_result_t average_run();
    int            aavg [3];
    int            gavg [3];
    int            word;
    int            neg;
    calib_result_t r;
    for (int i = 0; i < 3; i++) begin
      if (packets_held == 0) begin
        aavg[i] = 0;
        gavg[i] = 0;
      end else begin
        aavg[i] = accel_sum[i] / int'(packets_held);
        gavg[i] = gyro_sum[i] / int'(packets_held);
      end
    end
    // Take one gravity off the z axis, towards zero.
    if (aavg[2] > 0) begin
      aavg[2] -= int'(GRAVITY_COUNTS);
    end else begin
      aavg[2] += int'(GRAVITY_COUNTS);
    end
    for (int i = 0; i < 3; i++) begin
      word = int'(trim[i]) - aavg[i] / 8;
      neg  = (-gavg[i]) / 4;
      r.accel_avg[i] = aavg[i][15:0];
      r.gyro_avg[i]  = gavg[i][15:0];
      r.gyro_off[i]  = neg[14:0];
      r.accel_off[i] = word[15:0] | {15'd0, trim[i][0]};
    end
    return r;
  endfunction

  // Update the mirrored sums for one accepted packet.
  function automatic void accept_packet(packet_t p);
    if (packets_held < MAX_PACKETS) begin
      for (int i = 0; i < 3; i++) begin
        accel_sum[i] += int'($signed(p.accel[i]));
        gyro_sum[i]  += int'($signed(p.gyro[i]));
      end
      packets_held++;
    end
    if (p.last) begin
      result_q.push_back(average_run());
      for (int i = 0; i < 3; i++) begin
        accel_sum[i] = 0;
        gyro_sum[i]  = 0;
      end
      packets_held = 0;
    end
  endfunction

  function automatic packet_t make_packet(int ax, int ay, int az, int gx, int gy, int gz,
                                          logic last);
    packet_t p;
    p.accel[0] = sample_t'(ax);
    p.accel[1] = sample_t'(ay);
    p.accel[2] = sample_t'(az);
    p.gyro[0]  = sample_t'(gx);
    p.gyro[1]  = sample_t'(gy);
    p.gyro[2]  = sample_t'(gz);
    p.last     = last;
    return p;
  endfunction

  function automatic sample_t pick_sample(fill_e fill, int base);
    sample_t v;
    case (fill)
      FILL_RANDOM: begin
        v = sample_t'($urandom_range(0, 65535));
      end
      FILL_AT_REST: begin
        v = sample_t'(base + int'($urandom_range(0, 64)) - 32);
      end
      default: begin
        case ($urandom_range(0, 3))
          0:       v = 16'sh8000;
          1:       v = 16'sh7fff;
          2:       v = 16'sh0000;
          default: v = 16'shffff;
        endcase
      end
    endcase
    return v;
  endfunction

  function automatic fill_e pick_fill();
    int unsigned r;
    r = $urandom_range(0, 9);
    if (r < 2) begin
      return FILL_RANDOM;
    end else if (r < 8) begin
      return FILL_AT_REST;
    end
    return FILL_EXTREME;
  endfunction

  // Mostly short runs, some long ones and a few at or past the packet limit.
  function automatic int unsigned pick_run_len();
    int unsigned r;
    r = $urandom_range(0, 9);
    if (r < 7) begin
      return $urandom_range(1, 6);
    end else if (r < 9) begin
      return $urandom_range(7, MAX_PACKETS);
    end
    return $urandom_range(MAX_PACKETS, MAX_PACKETS + 8);
  endfunction

  // Offer one packet and wait for its transfer; returns at a falling edge.
  task automatic send_packet(packet_t p);
    if ($urandom_range(0, 99) < send_idle_pct) begin
      pkt_if.valid = 1'b0;
      do @(negedge clk); while ($urandom_range(0, 99) < send_idle_pct);
    end
    pkt_if.valid   = 1'b1;
    pkt_if.accel_x = p.accel[0];
    pkt_if.accel_y = p.accel[1];
    pkt_if.accel_z = p.accel[2];
    pkt_if.gyro_x  = p.gyro[0];
    pkt_if.gyro_y  = p.gyro[1];
    pkt_if.gyro_z  = p.gyro[2];
    pkt_if.last    = p.last;
    do @(posedge clk); while (!pkt_if.ready);
    accept_packet(p);
    items_sent++;
    @(negedge clk);
  endtask

  // One calibration run: bases per channel, noise per packet, last on the final one.
  task automatic send_run(int unsigned len, fill_e fill);
    int      base [6];
    packet_t p;
    base[0] = int'($urandom_range(0, 4000)) - 2000;
    base[1] = int'($urandom_range(0, 4000)) - 2000;
    base[2] = ($urandom_range(0, 1) ? 16384 : -16384) + int'($urandom_range(0, 4000)) - 2000;
    for (int i = 3; i < 6; i++) begin
      base[i] = int'($urandom_range(0, 1000)) - 500;
    end
    for (int unsigned k = 0; k < len; k++) begin
      for (int i = 0; i < 3; i++) begin
        p.accel[i] = pick_sample(fill, base[i]);
        p.gyro[i]  = pick_sample(fill, base[3 + i]);
      end
      p.last = (k == len - 1);
      send_packet(p);
    end
  endtask

  // Drop the packet valid and wait until the block has delivered everything.
  task automatic wait_idle();
    pkt_if.valid = 1'b0;
    while (result_q.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic write_trim(logic [CFG_IDX_W-1:0] idx, word_t value);
    wait_idle();
    cfg_if.valid = 1'b1;
    cfg_if.index = idx;
    cfg_if.data  = value;
    do @(posedge clk); while (!cfg_if.ready);
    if (idx < NUM_AXES) begin
      trim[idx] = sample_t'(value);
    end
    @(negedge clk);
    cfg_if.valid = 1'b0;
  endtask

  task automatic note_mismatch(string what, int axis, logic [15:0] want, logic [15:0] got);
    mismatches++;
    if (mismatches <= MAX_REPORTS) begin
      $display("mismatch %s[%0d]: expected 0x%04h, got 0x%04h", what, axis, want, got);
    end
  endtask

  // Single-packet and short runs at the extremes of every field.
  task automatic test_field_extremes();
    send_idle_pct = 0;
    recv_idle_pct = 0;
    send_packet(make_packet(32767, 32767, 32767, 32767, 32767, 32767, 1'b1));
    send_packet(make_packet(-32768, -32768, -32768, -32768, -32768, -32768, 1'b1));
    // Zero z average counts as not positive, so gravity is added.
    send_packet(make_packet(0, 0, 0, 0, 0, 0, 1'b1));
    send_packet(make_packet(-1, 1, 1, -1, 1, -1, 1'b1));
    send_packet(make_packet(1, -1, -1, 3, -3, 4, 1'b1));
    send_packet(make_packet(-9, 9, 16384, -7, 7, -8, 1'b1));
    send_packet(make_packet(9, -9, -16384, 5, -5, 8, 1'b1));
    // Sums that do not divide evenly truncate towards zero.
    send_packet(make_packet(-7, 7, 5, -5, 5, 1, 1'b0));
    send_packet(make_packet(-7, 7, 4, -5, 6, 1, 1'b0));
    send_packet(make_packet(-8, 8, 4, -6, 6, 2, 1'b1));
    // Opposite extremes that nearly cancel.
    send_packet(make_packet(32767, -32768, 32767, -32768, 32767, -32768, 1'b0));
    send_packet(make_packet(-32768, 32767, -32768, 32767, -32768, 32767, 1'b1));
    send_packet(make_packet(-15, 15, -16399, 31, -31, 30, 1'b1));
  endtask

  // Trim words at their extremes, both parities, and the spare index.
  task automatic test_trim_words();
    word_t settings [4][3];
    settings[0] = '{16'h7fff, 16'h8000, 16'h0001};
    settings[1] = '{16'hffff, 16'h0000, 16'h8001};
    settings[2] = '{16'h5555, 16'haaaa, 16'h0002};
    settings[3] = '{word_t'($urandom_range(0, 65535)), word_t'($urandom_range(0, 65535)),
                    word_t'($urandom_range(0, 65535))};
    for (int s = 0; s < 4; s++) begin
      write_trim(CFG_TRIM_X, settings[s][0]);
      write_trim(CFG_TRIM_Y, settings[s][1]);
      write_trim(CFG_TRIM_Z, settings[s][2]);
      send_run(2, FILL_AT_REST);
      send_run(1, FILL_EXTREME);
    end
    write_trim(CFG_IDX_SPARE, 16'hffff);
    send_run(2, FILL_RANDOM);
  endtask

  // Runs that reach and pass the packet limit; extra packets are dropped.
  task automatic test_packet_limit();
    send_run(MAX_PACKETS, FILL_EXTREME);
    send_run(MAX_PACKETS + 1, FILL_EXTREME);
    send_run(MAX_PACKETS + 36, FILL_AT_REST);
  endtask

  task automatic test_random_runs(int unsigned send_pct, int unsigned recv_pct);
    int unsigned start;
    int unsigned runs;
    send_idle_pct = send_pct;
    recv_idle_pct = recv_pct;
    start = items_sent;
    runs  = 0;
    while (items_sent - start < RUN_ITEMS) begin
      if (runs % 12 == 11) begin
        write_trim(cfg_idx_e'($urandom_range(0, 2)), word_t'($urandom_range(0, 65535)));
      end
      send_run(pick_run_len(), pick_fill());
      runs++;
    end
  endtask

  // Hold the result channel off while short runs keep arriving.
  task automatic test_result_stall();
    send_idle_pct = 0;
    recv_idle_pct = 0;
    @(posedge clk);
    hold_req = 1'b1;
    @(negedge clk);
    for (int r = 0; r < 10; r++) begin
      send_run($urandom_range(1, 4), pick_fill());
    end
  endtask

  // Result side ready, with random idling and an occasional long hold-off.
  always @(negedge clk) begin
    if (hold_req) begin
      hold_left = HOLD_CYCLES;
      hold_req  = 1'b0;
    end
    if (hold_left > 0) begin
      hold_left--;
      res_if.ready <= 1'b0;
    end else begin
      res_if.ready <= ($urandom_range(0, 99) >= recv_idle_pct);
    end
  end

  // Compare each result transfer with the oldest expectation.
  always @(posedge clk) begin : check_results
    calib_result_t want;
    calib_result_t got;
    if (rst_n && res_if.valid && res_if.ready) begin
      got.accel_avg = {res_if.accel_avg_z, res_if.accel_avg_y, res_if.accel_avg_x};
      got.gyro_avg  = {res_if.gyro_avg_z, res_if.gyro_avg_y, res_if.gyro_avg_x};
      got.gyro_off  = {res_if.gyro_offset_z, res_if.gyro_offset_y, res_if.gyro_offset_x};
      got.accel_off = {res_if.accel_offset_z, res_if.accel_offset_y, res_if.accel_offset_x};
      if (result_q.size() == 0) begin
        mismatches++;
        if (mismatches <= MAX_REPORTS) begin
          $display("mismatch: result transfer with no expectation waiting");
        end
      end else begin
        want = result_q.pop_front();
        for (int i = 0; i < 3; i++) begin
          if (got.accel_avg[i] !== want.accel_avg[i]) begin
            note_mismatch("accel_avg", i, want.accel_avg[i], got.accel_avg[i]);
          end
          if (got.gyro_avg[i] !== want.gyro_avg[i]) begin
            note_mismatch("gyro_avg", i, want.gyro_avg[i], got.gyro_avg[i]);
          end
          if (got.gyro_off[i] !== want.gyro_off[i]) begin
            note_mismatch("gyro_offset", i, want.gyro_off[i], got.gyro_off[i]);
          end
          if (got.accel_off[i] !== want.accel_off[i]) begin
            note_mismatch("accel_offset", i, want.accel_off[i], got.accel_off[i]);
          end
        end
      end
    end
  end

  // Watchdog.
  always @(posedge clk) begin
    cycles++;
    if (cycles > LIMIT_CYCLES) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  // Test sequence.
  initial begin
    rst_n          = 1'b0;
    pkt_if.valid   = 1'b0;
    pkt_if.accel_x = '0;
    pkt_if.accel_y = '0;
    pkt_if.accel_z = '0;
    pkt_if.gyro_x  = '0;
    pkt_if.gyro_y  = '0;
    pkt_if.gyro_z  = '0;
    pkt_if.last    = 1'b0;
    cfg_if.valid   = 1'b0;
    cfg_if.index   = CFG_TRIM_X;
    cfg_if.data    = '0;
    res_if.ready   = 1'b0;
    hold_req       = 1'b0;
    hold_left      = 0;
    cycles         = 0;
    mismatches     = 0;
    items_sent     = 0;
    send_idle_pct  = 0;
    recv_idle_pct  = 0;
    packets_held   = 0;
    for (int i = 0; i < 3; i++) begin
      accel_sum[i] = 0;
      gyro_sum[i]  = 0;
      trim[i]      = '0;
    end
    repeat (4) @(negedge clk);
    rst_n = 1'b1;

    test_field_extremes();
    test_trim_words();
    test_packet_limit();
    test_random_runs(7, 70);
    test_random_runs(70, 7);
    test_random_runs(0, 0);
    test_result_stall();

    wait_idle();
    if (mismatches == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
